/* src/relative_residual_max_norm_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the relative residual max-norm block
// Each macro expects clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef RELATIVE_RESIDUAL_MAX_NORM_ASSERT_SVH
`define RELATIVE_RESIDUAL_MAX_NORM_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define RRMN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define RRMN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/rrmn_pkg.sv */
// ----------------------------------------------------------------------------
// rrmn_pkg
// Shared constants, types and saturating arithmetic for the relative
// residual max-norm block.
// ----------------------------------------------------------------------------
package rrmn_pkg;

	// Fixed-point format of the streamed values
	localparam int FRAC_BITS = 16;
	localparam int ELEM_W    = 32;
	localparam int ACC_W     = 2 * ELEM_W;

	// Restoring divider: one quotient bit per cycle
	localparam int DIV_STEPS = ELEM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	typedef struct packed {
		acc_t val;
		logic ovf;
	} sat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_RES,
		ST_MAG,
		ST_MAX,
		ST_CHK,
		ST_DIV,
		ST_FIN
	} ctrl_state_t;

	// Commands from controller to datapath, at most one set per cycle
	typedef struct packed {
		logic load;
		logic mul;
		logic acc;
		logic res;
		logic mag;
		logic max;
		logic chk;
		logic step;
		logic finish;
	} rrmn_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic close;
		logic mend;
		logic out_free;
	} rrmn_stat_t;

	// Signed add, clamped to the 64-bit range
	function automatic sat_t sat_add(acc_t a, acc_t b);
		sat_t r;
		acc_t s;
		s = a + b;
		r.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
		if (r.ovf) begin
			r.val = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r.val = s;
		end
		return r;
	endfunction

	// Signed subtract, clamped to the 64-bit range
	function automatic sat_t sat_sub(acc_t a, acc_t b);
		sat_t r;
		acc_t s;
		s = a - b;
		r.ovf = (a[ACC_W-1] != b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
		if (r.ovf) begin
			r.val = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r.val = s;
		end
		return r;
	endfunction

endpackage

/* src/rrmn_item_if.sv */
// ----------------------------------------------------------------------------
// rrmn_item_if
// Input channel: one matrix element with its x(j), b(i) and row markers.
// ----------------------------------------------------------------------------
interface rrmn_item_if;
	import rrmn_pkg::*;

	logic  valid;
	logic  ready;
	elem_t a_elem;
	elem_t x_elem;
	elem_t b_elem;
	logic  row_end;
	logic  matrix_end;

	modport source (output valid, a_elem, x_elem, b_elem, row_end, matrix_end, input ready);
	modport sink   (input valid, a_elem, x_elem, b_elem, row_end, matrix_end, output ready);
endinterface

/* src/rrmn_result_if.sv */
// ----------------------------------------------------------------------------
// rrmn_result_if
// Output channel: one ratio item per matrix with its flags.
// ----------------------------------------------------------------------------
interface rrmn_result_if;
	import rrmn_pkg::*;

	logic              valid;
	logic              ready;
	logic [ELEM_W-1:0] ratio;
	logic              zero_divisor;
	logic              overflow;
	logic              last;

	modport source (output valid, ratio, zero_divisor, overflow, last, input ready);
	modport sink   (input valid, ratio, zero_divisor, overflow, last, output ready);
endinterface

/* src/relative_residual_max_norm.sv */
// The last item of a matrix gives its result after row close, the restoring divider
// and the output register. The sequencer takes one element at a time through the
// shared multiply-accumulate and takes no new element while it closes a row, runs
// the divider or waits for the output register to take a result.
// Reset: arst_n clears the sequencer, the accumulator, the maxima and output valid.
// ----------------------------------------------------------------------------
// relative_residual_max_norm
// Streams a matrix with x and b, tracks max |A x - b| and max |b| per matrix
// and emits their ratio in unsigned fixed point with saturation flags.
// ----------------------------------------------------------------------------
module relative_residual_max_norm import rrmn_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rrmn_item_if.sink     item_ch,
	rrmn_result_if.source result_ch
);

	rrmn_cmd_t  cmd;
	rrmn_stat_t stat;

	rrmn_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_ch.valid),
		.item_ready (item_ch.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	rrmn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.a_elem       (item_ch.a_elem),
		.x_elem       (item_ch.x_elem),
		.b_elem       (item_ch.b_elem),
		.row_end      (item_ch.row_end),
		.matrix_end   (item_ch.matrix_end),
		.out_valid    (result_ch.valid),
		.out_ready    (result_ch.ready),
		.ratio        (result_ch.ratio),
		.zero_divisor (result_ch.zero_divisor),
		.overflow     (result_ch.overflow)
	);

	// Every item is the single result of its matrix
	assign result_ch.last = 1'b1;

endmodule

/* src/rrmn_ctrl.sv */
// ----------------------------------------------------------------------------
// rrmn_ctrl
// Sequencer: steps each item through multiply and accumulate, closes a row
// at its end; at a matrix end runs the divider and feeds the output register.
// ----------------------------------------------------------------------------
module rrmn_ctrl import rrmn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  rrmn_stat_t stat,
	output rrmn_cmd_t  cmd
);

	ctrl_state_t          state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

	// State and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = stat.close ? ST_RES : ST_IDLE;
			end
			ST_RES: begin
				cmd.res = 1'b1;
				state_d = ST_MAG;
			end
			ST_MAG: begin
				cmd.mag = 1'b1;
				state_d = ST_MAX;
			end
			ST_MAX: begin
				cmd.max = 1'b1;
				state_d = stat.mend ? ST_CHK : ST_IDLE;
			end
			ST_CHK: begin
				cmd.chk = 1'b1;
				cnt_d   = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold until the output register can take the item
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* src/rrmn_dp.sv */
// ----------------------------------------------------------------------------
// rrmn_dp
// Datapath: multiplier, saturating accumulator, residual and maximum
// tracking, restoring divider and the output register.
// ----------------------------------------------------------------------------
`include "relative_residual_max_norm_assert.svh"

module rrmn_dp import rrmn_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rrmn_cmd_t         cmd,
	output rrmn_stat_t        stat,
	input  elem_t             a_elem,
	input  elem_t             x_elem,
	input  elem_t             b_elem,
	input  logic              row_end,
	input  logic              matrix_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ELEM_W-1:0] ratio,
	output logic              zero_divisor,
	output logic              overflow
);

	// Held item and intermediate values
	elem_t             a_q, x_q, b_q;
	acc_t              prod_q;
	acc_t              diff_q;
	logic [ACC_W-1:0]  res_q;
	logic [ELEM_W-1:0] bmag_q;

	// Running state for the current matrix
	logic              close_q, mend_q;
	acc_t              acc_q;
	logic [ACC_W-1:0]  max_res_q;
	logic [ELEM_W-1:0] max_rhs_q;
	logic              ovf_q;

	// Divider
	logic [ELEM_W-1:0] rem_q, quo_q;
	logic              zero_q, big_q;

	// Output register
	logic              out_valid_q;
	logic [ELEM_W-1:0] ratio_q;
	logic              zdiv_q, oflow_q;

	acc_t              prod_full;
	acc_t              bs;
	sat_t              acc_sum;
	sat_t              diff_sat;
	logic [ELEM_W:0]   trial;
	logic [ELEM_W:0]   trial_sub;
	logic              trial_ge;

	assign prod_full = a_q * x_q;
	assign bs        = {{(ACC_W-ELEM_W){b_q[ELEM_W-1]}}, b_q} <<< FRAC_BITS;
	assign acc_sum   = sat_add(acc_q, prod_q);
	assign diff_sat  = sat_sub(acc_q, bs);
	assign trial     = {rem_q, quo_q[ELEM_W-1]};
	assign trial_sub = trial - {1'b0, max_rhs_q};
	assign trial_ge  = trial >= {1'b0, max_rhs_q};

	assign stat.close    = close_q;
	assign stat.mend     = mend_q;
	assign stat.out_free = !out_valid_q || out_ready;

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= a_elem;
			x_q <= x_elem;
			b_q <= b_elem;
		end
		if (cmd.mul) begin
			prod_q <= prod_full;
		end
		if (cmd.res) begin
			diff_q <= diff_sat.val;
		end
		if (cmd.mag) begin
			res_q  <= diff_q[ACC_W-1] ? ACC_W'(0) - diff_q : diff_q;
			bmag_q <= b_q[ELEM_W-1] ? ELEM_W'(0) - b_q : b_q;
		end
		// Seed the divider with the top half as partial remainder
		if (cmd.chk) begin
			zero_q <= (max_rhs_q == '0);
			big_q  <= (max_res_q[ACC_W-1:ELEM_W] >= max_rhs_q);
			rem_q  <= max_res_q[ACC_W-1:ELEM_W];
			quo_q  <= max_res_q[ELEM_W-1:0];
		end
		// One quotient bit a cycle, shifted in behind the dividend
		if (cmd.step) begin
			rem_q <= trial_ge ? trial_sub[ELEM_W-1:0] : trial[ELEM_W-1:0];
			quo_q <= {quo_q[ELEM_W-2:0], trial_ge};
		end
		if (cmd.finish) begin
			ratio_q <= (zero_q || big_q) ? '1 : quo_q;
			zdiv_q  <= zero_q;
			oflow_q <= ovf_q || (big_q && !zero_q);
		end
	end

	// Matrix state: accumulate, close rows, clear after the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_q   <= 1'b0;
			mend_q    <= 1'b0;
			acc_q     <= '0;
			max_res_q <= '0;
			max_rhs_q <= '0;
			ovf_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				close_q <= row_end || matrix_end;
				mend_q  <= matrix_end;
			end
			if (cmd.acc) begin
				acc_q <= acc_sum.val;
				ovf_q <= ovf_q || acc_sum.ovf;
			end
			if (cmd.res) begin
				acc_q <= '0;
				ovf_q <= ovf_q || diff_sat.ovf;
			end
			if (cmd.max) begin
				if (res_q > max_res_q) begin
					max_res_q <= res_q;
				end
				if (bmag_q > max_rhs_q) begin
					max_rhs_q <= bmag_q;
				end
			end
			if (cmd.finish) begin
				acc_q     <= '0;
				max_res_q <= '0;
				max_rhs_q <= '0;
				ovf_q     <= 1'b0;
			end
		end
	end

	// Output valid: set on finish, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign ratio        = ratio_q;
	assign zero_divisor = zdiv_q;
	assign overflow     = oflow_q;

	`RRMN_ASSERT_NOW(a_no_overwrite, cmd.finish, !out_valid_q || out_ready, "result overwritten before it was taken")
	`RRMN_ASSERT_NEXT(a_finish_clears, cmd.finish, acc_q == '0 && max_res_q == '0 && max_rhs_q == '0 && !ovf_q, "matrix state not cleared after result")
	`RRMN_ASSERT_NOW(a_zero_saturates, out_valid_q && zdiv_q, ratio_q == '1, "zero divisor without saturated ratio")
	`RRMN_ASSERT_NEXT(a_rows_clear_acc, cmd.res, acc_q == '0, "accumulator not cleared at row close")

endmodule

/* tb/tb_relative_residual_max_norm.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_relative_residual_max_norm
// Streams matrices through the residual max-norm block and compares every
// ratio item with a local fixed-point model. The model keeps the saturating
// row sum, the largest residual and the largest |b|. Both channels idle at
// random, and the result side holds off once for a long stretch so that the
// block backs up.
// ----------------------------------------------------------------------------
module tb_relative_residual_max_norm;
	import rrmn_pkg::*;

	localparam acc_t  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam elem_t E_MAX   = 32'sh7FFF_FFFF;
	localparam elem_t E_MIN   = 32'sh8000_0000;
	localparam elem_t E_ONE   = 32'sh0001_0000;
	localparam logic [ACC_W-1:0] RATIO_TOP = 64'h0000_0000_FFFF_FFFF;

	typedef struct {
		logic [ELEM_W-1:0] ratio;
		logic              zero_divisor;
		logic              overflow;
		logic              last;
	} ratio_rec_t;

	// Track the residual norm of the matrix in flight and the ratios owed
	class residual_norm_tracker;
		acc_t              row_sum;
		logic [ACC_W-1:0]  worst_res;
		logic [ELEM_W-1:0] worst_rhs;
		bit                clamped;
		ratio_rec_t        ratio_q[$];
		int unsigned       errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			row_sum   = '0;
			worst_res = '0;
			worst_rhs = '0;
			clamped   = 1'b0;
		endfunction

		// Clamp a wide signed value to the accumulator range
		function acc_t clamp(logic signed [ACC_W+1:0] w);
			if (w > ACC_MAX) begin
				clamped = 1'b1;
				return ACC_MAX;
			end
			if (w < ACC_MIN) begin
				clamped = 1'b1;
				return ACC_MIN;
			end
			return w[ACC_W-1:0];
		endfunction

		// Fold one accepted element into the running norms
		function void take_element(elem_t a, elem_t x, elem_t b, logic rend, logic mend);
			logic signed [ACC_W+1:0] wsum;
			acc_t                    prod;
			acc_t                    rhs_scaled;
			acc_t                    diff;
			logic [ACC_W-1:0]        res_mag;
			logic [ELEM_W-1:0]       rhs_mag;
			logic [ACC_W-1:0]        quot;
			ratio_rec_t              rec;
			prod    = acc_t'(a) * acc_t'(x);
			wsum    = row_sum;
			wsum    = wsum + prod;
			row_sum = clamp(wsum);
			// close the row; a matrix end closes it too
			if (rend || mend) begin
				rhs_scaled = acc_t'(b) <<< FRAC_BITS;
				wsum       = row_sum;
				wsum       = wsum - rhs_scaled;
				diff       = clamp(wsum);
				res_mag    = diff[ACC_W-1] ? -diff : diff;
				rhs_mag    = b[ELEM_W-1] ? -b : b;
				if (res_mag > worst_res)
					worst_res = res_mag;
				if (rhs_mag > worst_rhs)
					worst_rhs = rhs_mag;
				row_sum = '0;
			end
			if (mend) begin
				rec.last         = 1'b1;
				rec.overflow     = clamped;
				rec.zero_divisor = 1'b0;
				if (worst_rhs == '0) begin
					rec.ratio        = '1;
					rec.zero_divisor = 1'b1;
				end else begin
					quot = worst_res / worst_rhs;
					if (quot > RATIO_TOP) begin
						rec.ratio    = '1;
						rec.overflow = 1'b1;
					end else begin
						rec.ratio = quot[ELEM_W-1:0];
					end
				end
				ratio_q.push_back(rec);
				clear();
			end
		endfunction

		// Compare one ratio item with the oldest owed ratio
		function void match_ratio(logic [ELEM_W-1:0] ratio, logic zd, logic ov, logic lst);
			ratio_rec_t want;
			if (ratio_q.size() == 0) begin
				$error("ratio item with no matrix pending: ratio %h", ratio);
				errors++;
				return;
			end
			want = ratio_q.pop_front();
			if (ratio !== want.ratio) begin
				$error("ratio: expected %h, actual %h", want.ratio, ratio);
				errors++;
			end
			if (zd !== want.zero_divisor) begin
				$error("zero_divisor: expected %b, actual %b", want.zero_divisor, zd);
				errors++;
			end
			if (ov !== want.overflow) begin
				$error("overflow: expected %b, actual %b", want.overflow, ov);
				errors++;
			end
			if (lst !== want.last) begin
				$error("last: expected %b, actual %b", want.last, lst);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rrmn_item_if   item_ch();
	rrmn_result_if result_ch();

	relative_residual_max_norm u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_ch  (item_ch),
		.result_ch(result_ch)
	);

	residual_norm_tracker tracker = new();
	int unsigned items_sent   = 0;
	int unsigned results_seen = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Sample both channels at the rising edge
	always @(posedge clk) begin
		if (item_ch.valid === 1'b1 && item_ch.ready === 1'b1)
			tracker.take_element(item_ch.a_elem, item_ch.x_elem, item_ch.b_elem,
				item_ch.row_end, item_ch.matrix_end);
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			tracker.match_ratio(result_ch.ratio, result_ch.zero_divisor,
				result_ch.overflow, result_ch.last);
			results_seen++;
		end
	end

	// Drive ready: random stalls, one long hold-off, one calm stretch
	initial begin
		int unsigned hold_left;
		bit          held;
		hold_left       = 0;
		held            = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 12) begin
				held      = 1'b1;
				hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (results_seen >= 40 && results_seen < 70) begin
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= 38);
			end
		end
	end

	// Offer one item, with random gaps ahead of it, and wait for acceptance
	task automatic send_element(elem_t a, elem_t x, elem_t b, logic re, logic me);
		while (!(items_sent >= 500 && items_sent < 800) && $urandom_range(99) < 38) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.a_elem     <= a;
		item_ch.x_elem     <= x;
		item_ch.b_elem     <= b;
		item_ch.row_end    <= re;
		item_ch.matrix_end <= me;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		items_sent++;
		@(negedge clk);
	endtask

	// Mostly moderate magnitudes; mixed matrices add zeros, extremes and full range
	function automatic elem_t pick_value(bit mixed);
		elem_t       v;
		int unsigned roll;
		v    = $urandom;
		roll = $urandom_range(99);
		if (!mixed || roll < 40)
			return v >>> 12;
		if (roll < 50)
			return '0;
		if (roll < 65) begin
			case ($urandom_range(3))
				0:       return E_MIN;
				1:       return E_MAX;
				2:       return E_ONE;
				default: return -E_ONE;
			endcase
		end
		return v;
	endfunction

	// Send one random matrix of a few short rows
	task automatic send_matrix();
		int unsigned n_rows;
		int unsigned n_cols;
		bit          mixed;
		bit          zero_rhs;
		bit          open_end;
		bit          row_last;
		bit          mat_last;
		elem_t       rhs;
		n_rows   = $urandom_range(1, 5);
		mixed    = ($urandom_range(99) < 40);
		zero_rhs = ($urandom_range(9) == 0);
		open_end = ($urandom_range(99) < 15);
		for (int r = 0; r < n_rows; r++) begin
			n_cols = $urandom_range(1, 5);
			rhs    = zero_rhs ? elem_t'(0) : pick_value(mixed);
			for (int c = 0; c < n_cols; c++) begin
				row_last = (c == n_cols - 1);
				mat_last = row_last && (r == n_rows - 1);
				// b outside a row end is noise the block must ignore
				send_element(pick_value(mixed), pick_value(mixed),
					row_last ? rhs : elem_t'($urandom),
					row_last && !(mat_last && open_end), mat_last);
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.a_elem     = '0;
		item_ch.x_elem     = '0;
		item_ch.b_elem     = '0;
		item_ch.row_end    = 1'b0;
		item_ch.matrix_end = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// all-zero single element: zero divisor
		send_element('0, '0, '0, 1'b1, 1'b1);
		// huge product over a tiny b: ratio saturates
		send_element(E_MIN, E_MIN, 32'sd1, 1'b1, 1'b1);
		// accumulator clamps high, residual clamps against most negative b
		send_element(E_MIN, E_MIN, '0, 1'b0, 1'b0);
		send_element(E_MIN, E_MIN, '0, 1'b0, 1'b0);
		send_element(E_MIN, E_MIN, E_MIN, 1'b1, 1'b1);
		// accumulator clamps low; matrix end closes the row without row end
		send_element(E_MIN, E_MAX, '0, 1'b0, 1'b0);
		send_element(E_MIN, E_MAX, '0, 1'b0, 1'b0);
		send_element(E_MIN, E_MAX, E_MAX, 1'b0, 1'b1);
		// two rows, most negative b in the last
		send_element(E_ONE, E_ONE, E_ONE, 1'b1, 1'b0);
		send_element(32'sh0003_0000, 32'sh0002_0000, '0, 1'b0, 1'b0);
		send_element(32'shFFFF_8000, E_ONE, E_MIN, 1'b1, 1'b1);
		// large products but every b zero
		send_element(E_MAX, E_MAX, '0, 1'b1, 1'b0);
		send_element(E_MIN, E_MAX, '0, 1'b1, 1'b1);
		// exact ratio: residual 3.0 over b 2.0
		send_element(E_ONE, 32'sh0005_0000, 32'sh0002_0000, 1'b1, 1'b1);
		// tiny product against the largest b
		send_element(E_MAX, 32'sd1, E_MAX, 1'b1, 1'b1);

		while (items_sent < 1320)
			send_matrix();
		item_ch.valid <= 1'b0;

		// drain owed ratios, then let the block settle
		while (tracker.ratio_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (tracker.errors == 0)
			$display("tb_relative_residual_max_norm OK");
		else
			$display("tb_relative_residual_max_norm NOT OK");
		$finish;
	end

	// Stop a hung run
	initial begin
		#4000000;
		$display("tb_relative_residual_max_norm NOT OK");
		$finish;
	end

endmodule
